@@ rtl/obb_pkg.sv @@
// Shared types, constants and fixed-point helpers for the OBB separating-axis block.
package obb_pkg;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [1:0] {
        CMD_CORNER = 2'd0,
        CMD_AXIS   = 2'd1,
        CMD_CENTER = 2'd2,
        CMD_PUSH   = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIR, ST_AXLD, ST_AXWAIT, ST_CR0, ST_CR1, ST_CR2, ST_LSQ,
        ST_NSCALE, ST_NSQ, ST_NSQRT, ST_NDIV, ST_PRJRD, ST_PRJWAIT, ST_PRJ,
        ST_OVL, ST_FLIP, ST_NEXT, ST_OUT0, ST_OUT1, ST_OUT2, ST_DONE
    } state_t;

    // saturating add/sub
    function automatic coord_t sadd(coord_t a, coord_t b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s > $signed({1'b0, CMAX})) return CMAX;
        if (s < $signed({1'b1, CMIN})) return CMIN;
        return s[CW-1:0];
    endfunction

    function automatic coord_t ssub(coord_t a, coord_t b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} - {b[CW-1], b};
        if (s > $signed({1'b0, CMAX})) return CMAX;
        if (s < $signed({1'b1, CMIN})) return CMIN;
        return s[CW-1:0];
    endfunction

    // Q product: truncate magnitude, saturate
    function automatic coord_t mulq(coord_t a, coord_t b);
        logic        neg;
        logic [CW-1:0] ua, ub;
        logic [2*CW-1:0] p, r;
        logic [CW-1:0] lim;
        neg = a[CW-1] ^ b[CW-1];
        ua = a[CW-1] ? CW'(-a) : CW'(a);
        ub = b[CW-1] ? CW'(-b) : CW'(b);
        p = ua * ub;
        r = p >> FB;
        lim = neg ? CMIN : CMAX;
        if (r > {{CW{1'b0}}, lim}) r = {{CW{1'b0}}, lim};
        return neg ? coord_t'(-r[CW-1:0]) : coord_t'(r[CW-1:0]);
    endfunction

endpackage

@@ rtl/obb_isqrt.sv @@
// Bit-serial integer square root for axis normalization.
module obb_isqrt
    import obb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] v_reg, r_reg, bit_reg;
    logic        busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                v_reg    <= radicand;
                r_reg    <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end else if (busy_reg) begin
                if (bit_reg == '0) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end else begin
                    if (v_reg >= r_reg + bit_reg) begin
                        v_reg <= v_reg - (r_reg + bit_reg);
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
        end
    end

    assign root = r_reg[31:0];
endmodule

@@ rtl/obb_separating_axis_push.sv @@
// Top level: OBB separating-axis test with minimum push vector.
//
// Input channel s_axis: one beat per command. tuser = {slot, box_select, command}
// (command in bits 1:0), tdata = {coord_z, coord_y, coord_x}, x lowest.
// Loads (corner, axis, center) are written into the corner, axis and
// center memories and give no result. A compute beat walks up to
// fifteen axes: for each, sixteen corners are read from the corner memory
// (one read per cycle) and projected through combinational multipliers;
// cross-product axes are normalized by a bit-serial square root and a
// restoring divider run once per component; a cross product whose squared
// length is at or below parallel_threshold is skipped. Input is stalled
// while a compute runs.
// Output channel m_axis: tuser = hit, tdata = {push_z, push_y, push_x}.
// The result is held in an output register until m_axis_tready; the next
// beat is accepted once the held result is taken.
// Reset (aresetn low, synchronous) clears control state and sets
// parallel_threshold to 7; stores are undefined until written.
module obb_separating_axis_push
    import obb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // coord_x, coord_y, coord_z
    input  logic [5:0]  s_axis_tuser,   // command[1:0], box_select, slot[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // push_x, push_y, push_z
    output logic        m_axis_tuser    // hit
);
    // memories: word = three coords
    logic [95:0] corner_mem [0:15];
    logic [95:0] axis_mem   [0:5];
    logic [95:0] center_mem [0:1];
    logic [95:0] corner_q, axis_q;

    logic [16:0] thr_reg;
    state_t      st_reg, st_next;

    logic [3:0]  ax_reg;       // 0..14
    logic [4:0]  k_reg;        // corner counter
    coord_t      dir_reg [3];
    coord_t      a_reg [3], b_reg [3], axv_reg [3], cr_reg [3];
    coord_t      minA_reg, maxA_reg, minB_reg, maxB_reg;
    coord_t      best_ov_reg, best_ax_reg [3];
    coord_t      ov_reg;
    logic [1:0]  comp_reg;
    logic [31:0] m_reg [3];
    logic [63:0] div_num_reg, div_rem_reg;
    logic [5:0]  div_cnt_reg;
    logic [31:0] len_reg;
    logic        hit_reg;
    logic [95:0] out_data_reg;
    logic        out_hit_reg, out_valid_reg;
    logic        sq_start;
    logic        sq_done;
    logic [31:0] sq_root;
    logic [63:0] sum_reg;
    logic [5:0]  dsh_reg;

    logic [1:0]  cmd;
    logic        box;
    logic [2:0]  slot;
    logic        s_fire;

    assign cmd  = s_axis_tuser[1:0];
    assign box  = s_axis_tuser[2];
    assign slot = s_axis_tuser[5:3];
    assign s_axis_tready = (st_reg == ST_IDLE) && !out_valid_reg;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    function automatic coord_t cx(logic [95:0] w, int i);
        return w[i*32 +: 32];
    endfunction

    function automatic logic [31:0] magf(coord_t v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // cross-product axis 6..14 -> A axis index i, B axis index j
    logic [1:0] cr_i, cr_j;
    always_comb begin
        case (ax_reg)
            4'd6:    begin cr_i = 2'd0; cr_j = 2'd0; end
            4'd7:    begin cr_i = 2'd0; cr_j = 2'd1; end
            4'd8:    begin cr_i = 2'd0; cr_j = 2'd2; end
            4'd9:    begin cr_i = 2'd1; cr_j = 2'd0; end
            4'd10:   begin cr_i = 2'd1; cr_j = 2'd1; end
            4'd11:   begin cr_i = 2'd1; cr_j = 2'd2; end
            4'd12:   begin cr_i = 2'd2; cr_j = 2'd0; end
            4'd13:   begin cr_i = 2'd2; cr_j = 2'd1; end
            4'd14:   begin cr_i = 2'd2; cr_j = 2'd2; end
            default: begin cr_i = 2'd0; cr_j = 2'd0; end
        endcase
    end

    // memory access
    logic [3:0] corner_ra;
    logic [2:0] axis_ra;
    always_comb begin
        corner_ra = {k_reg[3], k_reg[2:0]};
        axis_ra   = '0;
        case (st_reg)
            ST_AXLD: axis_ra = (ax_reg < 4'd6) ? 3'(ax_reg) : {1'b0, cr_i};
            ST_CR0:  axis_ra = 3'd3 + {1'b0, cr_j};
            default: axis_ra = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire && cmd == CMD_CORNER) corner_mem[{box, slot}] <= s_axis_tdata;
        if (s_fire && cmd == CMD_AXIS && slot < 3'd3)
            axis_mem[box ? 3'(slot + 3'd3) : slot] <= s_axis_tdata;
        if (s_fire && cmd == CMD_CENTER) center_mem[box] <= s_axis_tdata;
        corner_q <= corner_mem[corner_ra];
        axis_q   <= axis_mem[axis_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= 17'd7;
        else if (cfg_wr_en) thr_reg <= cfg_wr_data;
    end

    obb_isqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand(sum_reg), .done(sq_done), .root(sq_root)
    );
    assign sq_start = (st_reg == ST_NSQ);

    // dot of corner with axis, squared cross-product length, dot of center offset with axis
    coord_t dotv, lsq, flipd;
    assign dotv  = sadd(sadd(mulq(cx(corner_q,0), axv_reg[0]), mulq(cx(corner_q,1), axv_reg[1])),
                        mulq(cx(corner_q,2), axv_reg[2]));
    assign lsq   = sadd(sadd(mulq(cr_reg[0], cr_reg[0]), mulq(cr_reg[1], cr_reg[1])),
                        mulq(cr_reg[2], cr_reg[2]));
    assign flipd = sadd(sadd(mulq(dir_reg[0], axv_reg[0]), mulq(dir_reg[1], axv_reg[1])),
                        mulq(dir_reg[2], axv_reg[2]));

    logic [31:0] mx;
    assign mx = (m_reg[0] > m_reg[1]) ? ((m_reg[0] > m_reg[2]) ? m_reg[0] : m_reg[2])
                                      : ((m_reg[1] > m_reg[2]) ? m_reg[1] : m_reg[2]);

    coord_t   mn, mxo, ov_now;
    logic [63:0] trial;
    always_comb begin
        mn  = (minA_reg > minB_reg) ? minA_reg : minB_reg;
        mxo = (maxA_reg < maxB_reg) ? maxA_reg : maxB_reg;
        ov_now = ssub(mxo, mn);
        trial = {div_rem_reg[62:0], div_num_reg[63]};
    end

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:    if (s_fire && cmd == CMD_PUSH) st_next = ST_DIR;
            ST_DIR:     st_next = ST_AXLD;
            ST_AXLD:    st_next = ST_AXWAIT;
            ST_AXWAIT:  st_next = (ax_reg < 4'd6) ? ST_PRJRD : ST_CR0;
            ST_CR0:     st_next = ST_CR1;
            ST_CR1:     st_next = ST_CR2;
            ST_CR2:     st_next = ST_LSQ;
            ST_LSQ:     st_next = ($signed(lsq) <= $signed({15'd0, thr_reg})) ? ST_NEXT
                                  : ST_NSCALE;
            ST_NSCALE:  st_next = (mx >= 32'h4000_0000 || mx < 32'h2000_0000) ? ST_NSCALE
                                  : ST_NSQ;
            ST_NSQ:     st_next = ST_NSQRT;
            ST_NSQRT:   if (sq_done) st_next = ST_NDIV;
            ST_NDIV:    if (div_cnt_reg == 6'd0 && comp_reg == 2'd2 && dsh_reg == 6'd1)
                            st_next = ST_PRJRD;
            ST_PRJRD:   st_next = ST_PRJWAIT;
            ST_PRJWAIT: st_next = ST_PRJ;
            ST_PRJ:     if (k_reg == 5'd16) st_next = ST_OVL;
            ST_OVL:     st_next = ($signed(ov_now) <= 0) ? ST_OUT0 : ST_FLIP;
            ST_FLIP:    st_next = ST_NEXT;
            ST_NEXT:    st_next = (ax_reg == 4'd14) ? ST_OUT0 : ST_AXLD;
            ST_OUT0:    st_next = ST_OUT1;
            ST_OUT1:    st_next = ST_OUT2;
            ST_OUT2:    st_next = ST_DONE;
            ST_DONE:    st_next = ST_IDLE;
            default:    st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= ST_IDLE;
        else st_reg <= st_next;
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b1;
        end else begin
            if (m_axis_tvalid && m_axis_tready) out_valid_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: begin
                    ax_reg      <= '0;
                    hit_reg     <= 1'b1;
                    best_ov_reg <= CMAX;
                    for (int i = 0; i < 3; i++) best_ax_reg[i] <= '0;
                end
                ST_DIR: for (int i = 0; i < 3; i++)
                    dir_reg[i] <= ssub(cx(center_mem[0], i), cx(center_mem[1], i));
                ST_AXWAIT: begin
                    for (int i = 0; i < 3; i++) begin
                        axv_reg[i] <= cx(axis_q, i);
                        a_reg[i]   <= cx(axis_q, i);
                    end
                end
                ST_CR1: for (int i = 0; i < 3; i++) b_reg[i] <= cx(axis_q, i);
                ST_CR2: begin
                    cr_reg[0] <= ssub(mulq(a_reg[1], b_reg[2]), mulq(a_reg[2], b_reg[1]));
                    cr_reg[1] <= ssub(mulq(a_reg[2], b_reg[0]), mulq(a_reg[0], b_reg[2]));
                    cr_reg[2] <= ssub(mulq(a_reg[0], b_reg[1]), mulq(a_reg[1], b_reg[0]));
                end
                ST_LSQ: for (int i = 0; i < 3; i++) m_reg[i] <= magf(cr_reg[i]);
                ST_NSCALE: begin
                    if (mx >= 32'h4000_0000)
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                    else if (mx < 32'h2000_0000)
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
                    else
                        sum_reg <= 64'(m_reg[0]) * 64'(m_reg[0])
                                 + 64'(m_reg[1]) * 64'(m_reg[1])
                                 + 64'(m_reg[2]) * 64'(m_reg[2]);
                end
                ST_NSQ: begin
                    comp_reg <= '0;
                    dsh_reg  <= 6'd0;
                end
                ST_NSQRT: if (sq_done) begin
                    len_reg     <= sq_root;
                    div_num_reg <= 64'(m_reg[0]) << (FB + 16);
                    div_rem_reg <= '0;
                    div_cnt_reg <= 6'd48;
                end
                ST_NDIV: begin
                    if (div_cnt_reg != 6'd0) begin
                        if (trial >= 64'(len_reg)) begin
                            div_rem_reg <= trial - 64'(len_reg);
                            div_num_reg <= {div_num_reg[62:0], 1'b1};
                        end else begin
                            div_rem_reg <= trial;
                            div_num_reg <= {div_num_reg[62:0], 1'b0};
                        end
                        div_cnt_reg <= div_cnt_reg - 6'd1;
                        dsh_reg     <= 6'd0;
                    end else begin
                        // quotient sits in the lower 48 bits after 48 shifts
                        axv_reg[comp_reg] <= cr_reg[comp_reg][31]
                            ? coord_t'(-(div_num_reg[31:0])) : coord_t'(div_num_reg[31:0]);
                        dsh_reg <= 6'd1;
                        if (comp_reg != 2'd2) begin
                            comp_reg    <= comp_reg + 2'd1;
                            div_num_reg <= 64'(m_reg[comp_reg + 2'd1]) << (FB + 16);
                            div_rem_reg <= '0;
                            div_cnt_reg <= 6'd48;
                        end
                    end
                end
                ST_PRJRD: k_reg <= '0;
                ST_PRJWAIT: k_reg <= 5'd1;
                ST_PRJ: begin
                    if (k_reg != 5'd16) k_reg <= k_reg + 5'd1;
                    if (k_reg == 5'd1 || k_reg == 5'd9) begin
                        if (k_reg == 5'd1) begin minA_reg <= dotv; maxA_reg <= dotv; end
                        else begin minB_reg <= dotv; maxB_reg <= dotv; end
                    end else if (k_reg <= 5'd8) begin
                        if (dotv < minA_reg) minA_reg <= dotv;
                        if (dotv > maxA_reg) maxA_reg <= dotv;
                    end else begin
                        if (dotv < minB_reg) minB_reg <= dotv;
                        if (dotv > maxB_reg) maxB_reg <= dotv;
                    end
                end
                ST_OVL: begin
                    ov_reg <= ov_now;
                    if ($signed(ov_now) <= 0) hit_reg <= 1'b0;
                end
                ST_FLIP: if (ov_reg < best_ov_reg) begin
                    best_ov_reg <= ov_reg;
                    for (int i = 0; i < 3; i++)
                        best_ax_reg[i] <= flipd[31] ? ssub(32'sd0, axv_reg[i]) : axv_reg[i];
                end
                ST_NEXT: ax_reg <= ax_reg + 4'd1;
                ST_OUT0: out_data_reg[31:0]  <= hit_reg ? mulq(best_ax_reg[0], best_ov_reg) : '0;
                ST_OUT1: out_data_reg[63:32] <= hit_reg ? mulq(best_ax_reg[1], best_ov_reg) : '0;
                ST_OUT2: out_data_reg[95:64] <= hit_reg ? mulq(best_ax_reg[2], best_ov_reg) : '0;
                ST_DONE: begin
                    out_hit_reg   <= hit_reg;
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_hit_reg;
endmodule
